### src/mlt3_pkg.sv
`default_nettype none

package mlt3_pkg;

    localparam int WIN_SIDE  = 3;
    localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
    localparam int CENTER    = WIN_CELLS / 2;

    localparam logic [7:0] WHITE = 8'd255;
    localparam logic [7:0] BLACK = 8'd0;

    localparam int PIX_W = 8;
    localparam int LW_W  = 12;
    localparam int OFS_W = 9;
    localparam int CFG_W = 12;
    localparam int IDX_W = 1;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_OFFSET_C   = 1'b1
    } reg_idx_t;

    // Which row of the frame the next item belongs to.
    typedef enum logic [3:0] {
        ROW_FIRST  = 4'b0001,
        ROW_SECOND = 4'b0010,
        ROW_LATER  = 4'b0100,
        ROW_DONE   = 4'b1000
    } row_state_t;

    // Cell index is row * 3 + column, column 2 holds the newest pixels.
    typedef logic [WIN_CELLS-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic col0;
        logic zero_top;
        logic zero_mid;
        logic emit_first;
        logic at_edge;
        logic emit_edge;
        logic flush;
    } s1_ctl_t;

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic win_t shift_col(input win_t w, input logic [PIX_W-1:0] top,
                                       input logic [PIX_W-1:0] mid,
                                       input logic [PIX_W-1:0] bot);
        win_t n;
        n    = w;
        n[0] = w[1];
        n[1] = w[2];
        n[3] = w[4];
        n[4] = w[5];
        n[6] = w[7];
        n[7] = w[8];
        n[2] = top;
        n[5] = mid;
        n[8] = bot;
        return n;
    endfunction

    // Fixed 19 compare-exchange network; the fifth smallest ends in p[4].
    function automatic logic [PIX_W-1:0] median9(input win_t w);
        logic [PIX_W-1:0] p [WIN_CELLS];
        logic [PIX_W-1:0] t;
        for (int i = 0; i < WIN_CELLS; i++) begin
            p[i] = w[i];
        end
        t = min8(p[1], p[2]); p[2] = max8(p[1], p[2]); p[1] = t;
        t = min8(p[4], p[5]); p[5] = max8(p[4], p[5]); p[4] = t;
        t = min8(p[7], p[8]); p[8] = max8(p[7], p[8]); p[7] = t;
        t = min8(p[0], p[1]); p[1] = max8(p[0], p[1]); p[0] = t;
        t = min8(p[3], p[4]); p[4] = max8(p[3], p[4]); p[3] = t;
        t = min8(p[6], p[7]); p[7] = max8(p[6], p[7]); p[6] = t;
        t = min8(p[1], p[2]); p[2] = max8(p[1], p[2]); p[1] = t;
        t = min8(p[4], p[5]); p[5] = max8(p[4], p[5]); p[4] = t;
        t = min8(p[7], p[8]); p[8] = max8(p[7], p[8]); p[7] = t;
        t = min8(p[0], p[3]); p[3] = max8(p[0], p[3]); p[0] = t;
        t = min8(p[5], p[8]); p[8] = max8(p[5], p[8]); p[5] = t;
        t = min8(p[4], p[7]); p[7] = max8(p[4], p[7]); p[4] = t;
        t = min8(p[3], p[6]); p[6] = max8(p[3], p[6]); p[3] = t;
        t = min8(p[1], p[4]); p[4] = max8(p[1], p[4]); p[1] = t;
        t = min8(p[2], p[5]); p[5] = max8(p[2], p[5]); p[2] = t;
        t = min8(p[4], p[7]); p[7] = max8(p[4], p[7]); p[4] = t;
        t = min8(p[4], p[2]); p[2] = max8(p[4], p[2]); p[4] = t;
        t = min8(p[6], p[4]); p[4] = max8(p[6], p[4]); p[6] = t;
        t = min8(p[4], p[2]); p[2] = max8(p[4], p[2]); p[4] = t;
        return p[4];
    endfunction

endpackage

`default_nettype wire

### src/median_local_threshold_3x3_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    tdata: pixel; tuser: frame_start, flush
// m_*       out        m_tvalid/m_tready    tdata: binary_out; tuser: run_last;
//                                           tlast: frame_last
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One pixel per clock while the output is not stalled; a right-edge pixel holds the input
// while its two results leave one by one through the single output register.
// A result goes through the window stage and the output register after its pixel is accepted.
// Reset clears the control state and the window; the line stores are not cleared.
// A low m_tready backs up through the output register, window stage and
// input stage, after which s_tready drops.

module median_local_threshold_3x3_top #(
    parameter int MAX_LINE = 2048
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [7:0]                             s_tdata,   // [7:0] pixel
    input  wire logic [1:0]                             s_tuser,   // [0] frame_start, [1] flush
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [7:0]                                  m_tdata,   // [7:0] binary_out
    output logic [0:0]                                  m_tuser,   // [0] run_last
    output logic                                        m_tlast,   // frame_last
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [mlt3_pkg::IDX_W-1:0]             cfg_index,
    input  wire logic [mlt3_pkg::CFG_W-1:0]             cfg_data
);

    localparam int AW   = $clog2(MAX_LINE);
    localparam int WCMP = (AW + 1 > mlt3_pkg::LW_W) ? AW + 1 : mlt3_pkg::LW_W;

    // Configuration
    logic [AW-1:0]                 wm1_reg;     // clamped line width minus one
    logic [mlt3_pkg::OFS_W-1:0]    offset_reg;
    logic [WCMP-1:0]               cfg_w_ext;
    logic [AW-1:0]                 wm1_next;

    // Input stage
    logic                          s_fire;
    logic                          frame_start;
    logic                          flush_in;
    logic                          ignore;
    logic                          ld;
    mlt3_pkg::row_state_t          row_reg;
    mlt3_pkg::row_state_t          row_cur;
    mlt3_pkg::row_state_t          row_adv;
    logic [AW-1:0]                 col_reg;
    logic [AW-1:0]                 col_cur;
    logic                          at_edge;
    logic [7:0]                    pix_in;
    mlt3_pkg::s1_ctl_t             ctl_next;

    logic                          s1_valid_reg;
    mlt3_pkg::s1_ctl_t             s1_ctl_reg;
    logic [7:0]                    s1_pix_reg;
    logic [AW-1:0]                 s1_col_reg;

    logic [7:0]                    prev_mem [MAX_LINE];
    logic [7:0]                    older_mem [MAX_LINE];
    logic [7:0]                    rd_prev_reg;
    logic [7:0]                    rd_old_reg;
    logic                          fwd_reg;
    logic [7:0]                    fwd_data_reg;
    logic [7:0]                    top_raw;
    logic [7:0]                    top_px;
    logic [7:0]                    mid_px;

    // Window stage
    mlt3_pkg::win_t                window_reg;
    mlt3_pkg::win_t                win_base;
    mlt3_pkg::win_t                win_new;
    logic                          p_first_reg;
    logic                          p_edge_reg;
    logic                          s2_edge_reg;
    logic                          s2_flush_reg;
    logic                          pending;
    logic                          emit_fire;
    logic                          s2_ready;
    logic                          s1_adv;
    logic [7:0]                    med;
    logic signed [10:0]            thr;
    logic signed [10:0]            ctr;
    logic                          hit;

    // Output register
    logic                          out_valid_reg;
    logic [7:0]                    out_data_reg;
    logic                          out_run_reg;
    logic                          out_frame_reg;
    logic                          out_free;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_w_ext = WCMP'(cfg_data[mlt3_pkg::LW_W-1:0]);

    always_comb
    begin
        if (cfg_w_ext < WCMP'(2))
        begin
            wm1_next = AW'(1);
        end
        else if (cfg_w_ext > WCMP'(MAX_LINE))
        begin
            wm1_next = AW'(MAX_LINE - 1);
        end
        else
        begin
            wm1_next = AW'(cfg_w_ext - WCMP'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg    <= AW'(MAX_LINE - 1);
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mlt3_pkg::REG_LINE_WIDTH: wm1_reg    <= wm1_next;
                mlt3_pkg::REG_OFFSET_C:   offset_reg <= cfg_data[mlt3_pkg::OFS_W-1:0];
                default:                  offset_reg <= offset_reg;
            endcase
        end
    end

    // ---------------- input stage ----------------
    assign s_fire      = s_tvalid && s_tready;
    assign frame_start = s_tuser[0];
    assign flush_in    = s_tuser[1];
    assign row_cur     = frame_start ? mlt3_pkg::ROW_FIRST : row_reg;
    assign col_cur     = frame_start ? '0 : col_reg;
    // After the frame has ended, items without frame_start are taken and dropped.
    assign ignore      = !frame_start && (row_reg == mlt3_pkg::ROW_DONE);
    assign ld          = s_fire && !ignore;
    assign at_edge     = col_cur >= wm1_reg;
    assign pix_in      = flush_in ? 8'd0 : s_tdata;

    always_comb
    begin
        if (flush_in)
        begin
            row_adv = mlt3_pkg::ROW_DONE;
        end
        else
        begin
            case (row_cur)
                mlt3_pkg::ROW_FIRST:  row_adv = mlt3_pkg::ROW_SECOND;
                mlt3_pkg::ROW_SECOND: row_adv = mlt3_pkg::ROW_LATER;
                mlt3_pkg::ROW_LATER:  row_adv = mlt3_pkg::ROW_LATER;
                mlt3_pkg::ROW_DONE:   row_adv = mlt3_pkg::ROW_DONE;
                default:              row_adv = mlt3_pkg::ROW_FIRST;
            endcase
        end
    end

    always_comb
    begin
        ctl_next.col0       = (col_cur == '0);
        ctl_next.zero_top   = (row_cur == mlt3_pkg::ROW_FIRST) ||
                              (row_cur == mlt3_pkg::ROW_SECOND);
        ctl_next.zero_mid   = (row_cur == mlt3_pkg::ROW_FIRST);
        ctl_next.emit_first = (row_cur != mlt3_pkg::ROW_FIRST) && (col_cur != '0);
        ctl_next.at_edge    = at_edge;
        ctl_next.emit_edge  = at_edge && (row_cur != mlt3_pkg::ROW_FIRST);
        ctl_next.flush      = flush_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= mlt3_pkg::ROW_FIRST;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld)
            begin
                col_reg <= at_edge ? '0 : col_cur + 1'b1;
                row_reg <= at_edge ? row_adv : row_cur;
            end
            if (ld)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            s1_ctl_reg <= ctl_next;
            s1_pix_reg <= pix_in;
            s1_col_reg <= col_cur;
        end
    end

    // Previous line: read the old entry and store the new pixel in one access.
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            rd_prev_reg       <= prev_mem[col_cur];
            prev_mem[col_cur] <= pix_in;
        end
    end

    // Older line takes the previous-line value in the next cycle; a read of the
    // same column in that cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            older_mem[s1_col_reg] <= rd_prev_reg;
        end
        if (ld)
        begin
            rd_old_reg   <= older_mem[col_cur];
            fwd_reg      <= s1_valid_reg && (s1_col_reg == col_cur);
            fwd_data_reg <= rd_prev_reg;
        end
    end

    assign top_raw = fwd_reg ? fwd_data_reg : rd_old_reg;
    assign top_px  = s1_ctl_reg.zero_top ? 8'd0 : top_raw;
    assign mid_px  = s1_ctl_reg.zero_mid ? 8'd0 : rd_prev_reg;

    // ---------------- window stage ----------------
    assign win_base  = s1_ctl_reg.col0 ? '0 : window_reg;
    assign win_new   = mlt3_pkg::shift_col(win_base, top_px, mid_px, s1_pix_reg);

    assign pending   = p_first_reg || p_edge_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign emit_fire = pending && out_free;
    assign s2_ready  = !pending || (emit_fire && !(p_first_reg && p_edge_reg));
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s_tready  = !s1_valid_reg || s2_ready;

    assign med = mlt3_pkg::median9(window_reg);
    assign thr = $signed({3'b000, med}) - 11'(signed'(offset_reg));
    assign ctr = $signed({3'b000, window_reg[mlt3_pkg::CENTER]});
    assign hit = ctr > thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            p_first_reg <= 1'b0;
            p_edge_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            // A right-edge item with no first result goes straight to its padded window.
            window_reg  <= (s1_ctl_reg.at_edge && !s1_ctl_reg.emit_first) ?
                           mlt3_pkg::shift_col(win_new, 8'd0, 8'd0, 8'd0) : win_new;
            p_first_reg <= s1_ctl_reg.emit_first;
            p_edge_reg  <= s1_ctl_reg.emit_edge;
        end
        else if (emit_fire)
        begin
            if (p_first_reg)
            begin
                p_first_reg <= 1'b0;
                if (p_edge_reg)
                begin
                    window_reg <= mlt3_pkg::shift_col(window_reg, 8'd0, 8'd0, 8'd0);
                end
            end
            else
            begin
                p_edge_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_edge_reg  <= s1_ctl_reg.at_edge;
            s2_flush_reg <= s1_ctl_reg.flush;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg  <= hit ? mlt3_pkg::WHITE : mlt3_pkg::BLACK;
            out_run_reg   <= p_first_reg ? !s2_edge_reg : 1'b1;
            out_frame_reg <= p_first_reg ? 1'b0 : s2_flush_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_run_reg;
    assign m_tlast    = out_frame_reg;

endmodule

`default_nettype wire

### src/mlt3_checker.sv
`default_nettype none

module mlt3_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [7:0]                  s_tdata,
    input wire logic [1:0]                  s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [7:0]                  m_tdata,
    input wire logic [0:0]                  m_tuser,
    input wire logic                        m_tlast,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [mlt3_pkg::IDX_W-1:0]  cfg_index,
    input wire logic [mlt3_pkg::CFG_W-1:0]  cfg_data
);

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Results are binary.
    a_out_binary: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == mlt3_pkg::WHITE) || (m_tdata == mlt3_pkg::BLACK))
        else $error("result is neither black nor white");

    // The frame's final result is also the last one of its input transaction.
    a_frame_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without run end");

    // The configuration port never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transaction stalled");

endmodule

bind median_local_threshold_3x3_top mlt3_checker u_mlt3_checker (.*);

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mlt3_pkg::*;

    localparam int LINE_MAX     = 2048;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_GAP      = 40;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 50;

    typedef enum logic {
        OP_PIXEL,
        OP_WRITE
    } step_op_t;

    typedef struct packed {
        step_op_t   op;
        reg_idx_t   idx;
        logic [11:0] data;
        logic [7:0] pix;
        logic       fs;
        logic       fl;
        logic       typed;
        logic [7:0] val;
    } dir_step_t;

    typedef struct packed {
        logic [7:0] bin;
        logic       run_last;
        logic       frame_last;
    } pix_result_t;

    // Short directed sequence. Rows with typed set carry a known output level:
    // a huge positive offset makes every nonzero center white, a huge negative
    // one makes everything black.
    localparam int DIR_N = 29;
    localparam dir_step_t DIR_STEPS [DIR_N] = '{
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd10,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd20,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd30,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd40,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd50,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_WRITE, REG_LINE_WIDTH, 12'h004, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd60,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_WRITE, REG_OFFSET_C,   12'h0FF, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd0,   1'b0, 1'b0, 1'b1, WHITE},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd255, 1'b0, 1'b0, 1'b1, WHITE},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd0,   1'b0, 1'b0, 1'b1, WHITE},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd255, 1'b0, 1'b0, 1'b1, WHITE},
        '{OP_WRITE, REG_OFFSET_C,   12'hF01, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd255, 1'b0, 1'b0, 1'b1, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd255, 1'b0, 1'b1, 1'b1, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd0,   1'b0, 1'b0, 1'b1, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd128, 1'b0, 1'b0, 1'b1, BLACK},
        '{OP_WRITE, REG_OFFSET_C,   12'h000, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd200, 1'b0, 1'b1, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd200, 1'b0, 1'b1, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd200, 1'b0, 1'b1, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd200, 1'b0, 1'b1, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd77,  1'b0, 1'b0, 1'b0, BLACK},
        '{OP_WRITE, REG_LINE_WIDTH, 12'h001, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd255, 1'b1, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd0,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd5,   1'b0, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd100, 1'b1, 1'b0, 1'b0, BLACK},
        '{OP_PIXEL, REG_LINE_WIDTH, 12'h000, 8'd33,  1'b0, 1'b0, 1'b0, BLACK}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic [1:0]  s_tuser   = 2'b00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    reg_idx_t    cfg_index = REG_LINE_WIDTH;
    logic [11:0] cfg_data  = 12'd0;

    // Predictor state.
    logic [7:0]        older_mem [LINE_MAX];
    logic [7:0]        prev_mem [LINE_MAX];
    logic [7:0]        win_cells [WIN_CELLS] = '{default: 8'd0};
    int                col_cnt    = 0;
    row_state_t        row_st     = ROW_FIRST;
    logic [11:0]       width_reg  = 12'd2048;
    logic signed [8:0] offset_reg = 9'sd0;

    pix_result_t expected_pixels [$];
    int error_count = 0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_done   = 0;
    int hold_left   = 0;
    int low_run     = 0;

    median_local_threshold_3x3_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp_width(input logic [11:0] w);
        int v;
        v = w;
        if (v < 2)
            v = 2;
        if (v > LINE_MAX)
            v = LINE_MAX;
        return v;
    endfunction

    function automatic void shift_window(input logic [7:0] top, input logic [7:0] mid,
                                         input logic [7:0] bot);
        for (int r = 0; r < WIN_SIDE; r++)
        begin
            win_cells[r * 3 + 0] = win_cells[r * 3 + 1];
            win_cells[r * 3 + 1] = win_cells[r * 3 + 2];
        end
        win_cells[2] = top;
        win_cells[5] = mid;
        win_cells[8] = bot;
    endfunction

    function automatic logic [7:0] window_level();
        logic [7:0] v [WIN_CELLS];
        logic [7:0] t;
        int j;
        int ofs;
        for (int i = 0; i < WIN_CELLS; i++)
            v[i] = win_cells[i];
        for (int i = 1; i < WIN_CELLS; i++)
        begin
            t = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > t)
            begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = t;
        end
        ofs = offset_reg;
        return (int'(win_cells[CENTER]) > int'(v[CENTER]) - ofs) ? WHITE : BLACK;
    endfunction

    // Advances the predictor by one accepted pixel and queues what it causes.
    function automatic void binarize_pixel(input logic [7:0] pix, input logic fs,
                                           input logic fl, input logic typed,
                                           input logic [7:0] tval);
        int w;
        int c;
        logic at_edge;
        logic [7:0] p;
        logic [7:0] top;
        logic [7:0] mid;
        pix_result_t r;
        w = clamp_width(width_reg);
        if (fs)
        begin
            col_cnt = 0;
            row_st  = ROW_FIRST;
        end
        else if (row_st == ROW_DONE)
            return;
        p = fl ? 8'd0 : pix;
        c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
        at_edge = (c >= w - 1);
        top = (row_st == ROW_LATER) ? older_mem[c] : 8'd0;
        mid = (row_st != ROW_FIRST) ? prev_mem[c] : 8'd0;
        older_mem[c] = prev_mem[c];
        prev_mem[c]  = p;
        if (c == 0)
            win_cells = '{default: 8'd0};
        shift_window(top, mid, p);
        if (row_st != ROW_FIRST && c != 0)
        begin
            r.bin        = typed ? tval : window_level();
            r.run_last   = !at_edge;
            r.frame_last = 1'b0;
            expected_pixels.push_back(r);
        end
        if (at_edge)
        begin
            // The right-edge pixel also closes the last column of the row above.
            if (row_st != ROW_FIRST)
            begin
                shift_window(8'd0, 8'd0, 8'd0);
                r.bin        = typed ? tval : window_level();
                r.run_last   = 1'b1;
                r.frame_last = fl;
                expected_pixels.push_back(r);
            end
            col_cnt = 0;
            if (fl)
                row_st = ROW_DONE;
            else if (row_st == ROW_FIRST)
                row_st = ROW_SECOND;
            else
                row_st = ROW_LATER;
        end
        else
            col_cnt = c + 1;
    endfunction

    function automatic logic [7:0] pick_pixel(input int style, input int base);
        int v;
        case (style)
            0: v = $urandom_range(0, 255);
            1: v = $urandom_range(0, 1) ? 255 : 0;
            2: v = base + int'($urandom_range(0, 40)) - 20;
            default: v = $urandom_range(0, 3) ? base : int'($urandom_range(0, 255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // Called at a rising edge; returns at the edge where the pixel was taken.
    task automatic send_pixel(input logic [7:0] pix, input logic fs, input logic fl,
                              input logic typed, input logic [7:0] tval);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= {fl, fs};
        do
            @(posedge clk);
        while (!s_tready);
        binarize_pixel(pix, fs, fl, typed, tval);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [11:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_LINE_WIDTH)
            width_reg = data;
        else
            offset_reg = data[8:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Rows of the first line give no output, so after the last result the
    // pipeline may still hold pixels; let it settle for DRAIN_CYCLES before a write.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                             input bit pressure, input int width_sel, input int max_rows);
        int count;
        int w;
        int rows;
        int style;
        int base;
        int abort_at;
        int k;
        int ofs;
        logic [11:0] wdata;
        logic fl;
        drain_block();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (width_sel >= 0)
            wdata = width_sel[11:0];
        else
            case ($urandom_range(0, 9))
                0: wdata = $urandom_range(0, 1);
                1: wdata = $urandom_range(13, 40);
                default: wdata = $urandom_range(2, 12);
            endcase
        case ($urandom_range(0, 4))
            0: ofs = -255;
            1: ofs = 255;
            2: ofs = int'($urandom_range(0, 510)) - 255;
            default: ofs = int'($urandom_range(0, 60)) - 30;
        endcase
        write_reg(REG_LINE_WIDTH, wdata);
        write_reg(REG_OFFSET_C, 12'(ofs));
        w = clamp_width(wdata);
        count = 0;
        while (count < n_items)
        begin
            rows  = $urandom_range(1, max_rows);
            style = $urandom_range(0, 3);
            base  = $urandom_range(0, 255);
            // Now and then a frame is cut short by the next frame start.
            abort_at = (w <= 64 && $urandom_range(0, 9) == 0) ?
                       int'($urandom_range(0, (rows + 1) * w - 1)) : -1;
            k = 0;
            for (int r = 0; r <= rows && k != abort_at; r++)
            begin
                for (int c = 0; c < w && k != abort_at; c++)
                begin
                    fl = (r == rows) || (c != w - 1 && $urandom_range(0, 29) == 0);
                    if (pressure && count == 20)
                        hold_req++;
                    send_pixel(pick_pixel(style, base), r == 0 && c == 0, fl, 1'b0, BLACK);
                    k++;
                    count++;
                end
            end
            // Stray pixels after the bottom row must be dropped by the block.
            if (abort_at < 0 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_pixel($urandom_range(0, 255), 1'b0, $urandom_range(0, 1),
                               1'b0, BLACK);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_req;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (low_run < MAX_GAP && $urandom_range(0, 99) < rx_idle_pct)
        begin
            low_run++;
            m_tready <= 1'b0;
        end
        else
        begin
            low_run = 0;
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        pix_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= PRINT_LIMIT)
                    $display("%0t: unexpected transaction, expected none, got bin=%0d run_last=%0b frame_last=%0b",
                             $time, m_tdata, m_tuser[0], m_tlast);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.bin || m_tuser[0] !== want.run_last ||
                    m_tlast !== want.frame_last)
                begin
                    error_count++;
                    if (error_count <= PRINT_LIMIT)
                        $display("%0t: mismatch, expected bin=%0d run_last=%0b frame_last=%0b, got bin=%0d run_last=%0b frame_last=%0b",
                                 $time, want.bin, want.run_last, want.frame_last,
                                 m_tdata, m_tuser[0], m_tlast);
                end
            end
        end
    end

    initial
    begin : main_seq
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 35;
        rx_idle_pct = 83;
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_STEPS[i].op == OP_WRITE)
            begin
                drain_block();
                write_reg(DIR_STEPS[i].idx, DIR_STEPS[i].data);
            end
            else
                send_pixel(DIR_STEPS[i].pix, DIR_STEPS[i].fs, DIR_STEPS[i].fl,
                           DIR_STEPS[i].typed, DIR_STEPS[i].val);
        end

        run_phase(125, 35, 83, 1'b1, -1, 4);
        run_phase(125, 35, 83, 1'b0, -1, 4);
        run_phase(125, 83, 35, 1'b0, -1, 4);
        run_phase(125, 83, 35, 1'b0, -1, 4);
        run_phase(125, 0, 0, 1'b1, -1, 4);
        run_phase(125, 0, 0, 1'b0, -1, 4);
        // One frame at the widest line, written out of range so it clamps.
        run_phase(1, 0, 0, 1'b0, 4095, 1);

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results missing, oldest expected bin=%0d run_last=%0b frame_last=%0b",
                     $time, expected_pixels.size(), expected_pixels[0].bin,
                     expected_pixels[0].run_last, expected_pixels[0].frame_last);
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
src/mlt3_pkg.sv
src/median_local_threshold_3x3_top.sv
src/mlt3_checker.sv
sim/tb.sv
